// ----- rtl/pba_pkg.sv -----
// shared types, constants and codes for the page bitmap allocator
`timescale 1ns / 1ps

package pba_pkg;

  // default number of pages in the map
  localparam int DEF_PAGES = 256;

  // stream payload widths
  localparam int OP_W      = 3;
  localparam int PAGE_W    = 8;
  localparam int LEN_W     = 9;
  localparam int COUNT_W   = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // operation codes carried in the op field
  typedef enum logic [OP_W-1:0] {
    OP_MARK_USED = 3'd0,
    OP_MARK_FREE = 3'd1,
    OP_TEST      = 3'd2,
    OP_FIND      = 3'd3,
    OP_COUNT     = 3'd4
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new item and reset the scan state
    logic clear;     // write one free entry of the clearing pass
    logic wr_page;   // write the addressed page (mark used or free)
    logic rd_page;   // read the addressed page (test)
    logic scan;      // step the find or count scan
    logic out_load;  // load the result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic page_ok;
    logic len_zero;
    logic clear_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/page_bitmap_allocator.sv -----
// top level of the page bitmap allocator, one result per item
// mark and test go from decode straight to the result state; find (unless its run length is zero)
// and count first scan the map, reading one page per cycle through the single read port
// one item in work at a time, the next input transfer only once the controller is back in idle;
// input is taken while a result waits
// reset: rst starts a clearing pass that writes every page free, no transfer
`timescale 1ns / 1ps

module page_bitmap_allocator import pba_pkg::*; #(
  parameter int PAGES = DEF_PAGES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // op[2:0], page[10:3], run_length[19:11]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // status[0], start_page[8:1], used_flag[9],
                                                // used_count[17:10]
);

  cmd_t               cmd;
  sts_t               sts;
  logic               status;
  logic [PAGE_W-1:0]  start_page;
  logic               used_flag;
  logic [COUNT_W-1:0] used_count;

  // controller
  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  pba_datapath #(
    .PAGES (PAGES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (s_axis_tdata[2:0]),
    .page       (s_axis_tdata[10:3]),
    .run_length (s_axis_tdata[19:11]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .status     (status),
    .start_page (start_page),
    .used_flag  (used_flag),
    .used_count (used_count)
  );

  // pack the result transfer
  assign m_axis_tdata = {6'b0, used_count, used_flag, start_page, status};

endmodule

// ----- rtl/pba_ctrl.sv -----
// controller state machine for the page bitmap allocator
`timescale 1ns / 1ps

module pba_ctrl import pba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_FIND:  state_next = sts.len_zero ? ST_RESULT : ST_SCAN;
          OP_COUNT: state_next = ST_SCAN;
          default:  state_next = ST_RESULT;
        endcase
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_MARK_USED, OP_MARK_FREE: cmd.wr_page = sts.page_ok;
          OP_TEST:                    cmd.rd_page = 1'b1;
          default:                    cmd = '0;
        endcase
      end
      ST_SCAN:   cmd.scan = 1'b1;
      ST_RESULT: cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- rtl/pba_datapath.sv -----
// bitmap memory, scan counters and result register for the page bitmap allocator
`timescale 1ns / 1ps

module pba_datapath import pba_pkg::*; #(
  parameter int PAGES = DEF_PAGES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [OP_W-1:0]       op,
  input  logic [PAGE_W-1:0]     page,
  input  logic [LEN_W-1:0]      run_length,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  status,
  output logic [PAGE_W-1:0]     start_page,
  output logic                  used_flag,
  output logic [COUNT_W-1:0]    used_count
);

  localparam int AW = $clog2(PAGES);
  localparam int RW = $clog2(PAGES + 1);
  localparam int CW = (RW > LEN_W) ? RW : LEN_W;
  localparam int FW = ((AW > PAGE_W) ? AW : PAGE_W) + 2;
  localparam int SW = (AW > COUNT_W) ? AW : COUNT_W;
  localparam logic [AW-1:0] LAST = AW'(PAGES - 1);

  // item registers
  op_t               op_q;
  logic [PAGE_W-1:0] page_q;
  logic [LEN_W-1:0]  len_q;

  // bitmap storage, 1 means free
  logic              mem [PAGES];
  logic              rd_bit;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              wr_bit;

  // scan state
  logic [AW-1:0]     scan_addr;
  logic              issued_all;
  logic              rd_vld;
  logic [AW-1:0]     rd_addr_q;
  logic [RW-1:0]     run;
  logic [AW-1:0]     used;
  logic              found;
  logic [PAGE_W-1:0] first;
  logic              scan_done;

  // combinational helpers
  logic              page_ok;
  logic [AW-1:0]     page_addr;
  logic              proc;
  logic [RW-1:0]     run_inc;
  logic              hit;
  logic [FW-1:0]     first_calc;
  logic              addr_last;
  logic [SW-1:0]     used_ext;

  // result values
  logic              res_status;
  logic [PAGE_W-1:0] res_start;
  logic              res_used;
  logic [COUNT_W-1:0] res_count;

  // capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(op);
      page_q <= page;
      len_q  <= run_length;
    end
  end

  // address and write selection
  always_comb begin
    page_ok   = (13'(page_q) < 13'(PAGES));
    page_addr = AW'(page_q);
    rd_en     = (cmd.scan && !issued_all) || cmd.rd_page;
    rd_addr   = cmd.scan ? scan_addr : page_addr;
    wr_en     = cmd.clear || cmd.wr_page;
    wr_addr   = cmd.clear ? scan_addr : page_addr;
    wr_bit    = cmd.clear ? 1'b1 : (op_q == OP_MARK_FREE);
  end

  // bitmap memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_bit;
    if (rd_en) rd_bit <= mem[rd_addr];
  end

  // scan step on the returned bit
  always_comb begin
    proc       = cmd.scan && rd_vld && !scan_done;
    run_inc    = run + 1'b1;
    hit        = rd_bit && (op_q == OP_FIND) && (CW'(run_inc) == CW'(len_q));
    first_calc = FW'(rd_addr_q) + FW'(1) - FW'(len_q);
    addr_last  = (rd_addr_q == LAST);
  end

  // scan control registers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      issued_all <= 1'b0;
      rd_vld     <= 1'b0;
      run        <= '0;
      used       <= '0;
      found      <= 1'b0;
      scan_done  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_addr  <= '0;
        issued_all <= 1'b0;
        rd_vld     <= 1'b0;
        run        <= '0;
        used       <= '0;
        found      <= 1'b0;
        scan_done  <= 1'b0;
      end else begin
        if (cmd.clear) scan_addr <= scan_addr + 1'b1;
        if (cmd.scan && !issued_all) begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == LAST) issued_all <= 1'b1;
        end
        rd_vld <= cmd.scan && !issued_all;
        if (proc) begin
          if (op_q == OP_FIND) run <= rd_bit ? run_inc : '0;
          if (hit) found <= 1'b1;
          if ((op_q == OP_COUNT) && !rd_bit && !addr_last) used <= used + 1'b1;
          if (hit || addr_last) scan_done <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // address of the bit in flight and start of the found run
  always_ff @(posedge clk) begin
    rd_addr_q <= scan_addr;
    if (proc && hit) first <= first_calc[PAGE_W-1:0];
  end

  // result selection
  always_comb begin
    used_ext   = SW'(used);
    res_status = 1'b1;
    res_start  = '0;
    res_used   = 1'b0;
    res_count  = '0;
    unique case (op_q)
      OP_MARK_USED, OP_MARK_FREE: res_status = !page_ok;
      OP_TEST: begin
        res_status = !page_ok;
        res_used   = page_ok && !rd_bit;
      end
      OP_FIND: begin
        res_status = !found;
        res_start  = found ? first : '0;
      end
      OP_COUNT: begin
        res_status = 1'b0;
        res_count  = (used_ext > SW'(255)) ? {COUNT_W{1'b1}} : used_ext[COUNT_W-1:0];
      end
      default: res_status = 1'b1;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      start_page <= res_start;
      used_flag  <= res_used;
      used_count <= res_count;
    end
  end

  // status to the controller
  always_comb begin
    sts.op         = op_q;
    sts.page_ok    = page_ok;
    sts.len_zero   = (len_q == '0);
    sts.clear_last = (scan_addr == LAST);
    sts.scan_done  = scan_done;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
